### design/assert_macros.svh
// Assertion macros shared by the blend unit RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define RBFU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define RBFU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### design/rbfu_pkg.sv
// Types, register indexes and the blend factor selection function for the blend unit.
// Depends on nothing; imported by rbfu_lane and the top level.
package rbfu_pkg;

    typedef enum logic [3:0] {
        FACTOR_ZERO            = 4'd0,
        FACTOR_ONE             = 4'd1,
        FACTOR_DST_COLOR       = 4'd2,
        FACTOR_SRC_COLOR       = 4'd3,
        FACTOR_INV_DST_COLOR   = 4'd4,
        FACTOR_SRC_ALPHA       = 4'd5,
        FACTOR_INV_SRC_COLOR   = 4'd6,
        FACTOR_DST_ALPHA       = 4'd7,
        FACTOR_INV_DST_ALPHA   = 4'd8,
        FACTOR_SRC_ALPHA_SAT   = 4'd9,
        FACTOR_INV_SRC_ALPHA   = 4'd10
    } factor_sel_t;

    typedef struct packed {
        factor_sel_t src_sel;
        factor_sel_t dst_sel;
    } blend_cfg_t;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned NUM_LANES  = 4;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_SRC_FACTOR = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DST_FACTOR = 1'd1;

    localparam logic [CHAN_W-1:0] UNORM_ONE = 8'hFF;

    function automatic logic [CHAN_W-1:0] blend_factor(
        input factor_sel_t       sel,
        input logic [CHAN_W-1:0] s_ch,
        input logic [CHAN_W-1:0] d_ch,
        input logic [CHAN_W-1:0] s_a,
        input logic [CHAN_W-1:0] d_a,
        input logic              is_alpha
    );
        logic [CHAN_W-1:0] sat;
        sat = UNORM_ONE - d_a;
        case (sel)
            FACTOR_ZERO:          blend_factor = '0;
            FACTOR_ONE:           blend_factor = UNORM_ONE;
            FACTOR_DST_COLOR:     blend_factor = d_ch;
            FACTOR_SRC_COLOR:     blend_factor = s_ch;
            FACTOR_INV_DST_COLOR: blend_factor = UNORM_ONE - d_ch;
            FACTOR_SRC_ALPHA:     blend_factor = s_a;
            FACTOR_INV_SRC_COLOR: blend_factor = UNORM_ONE - s_ch;
            FACTOR_DST_ALPHA:     blend_factor = d_a;
            FACTOR_INV_DST_ALPHA: blend_factor = UNORM_ONE - d_a;
            FACTOR_SRC_ALPHA_SAT: begin
                if (is_alpha) begin
                    blend_factor = UNORM_ONE;
                end else begin
                    blend_factor = (s_a < sat) ? s_a : sat;
                end
            end
            FACTOR_INV_SRC_ALPHA: blend_factor = UNORM_ONE - s_a;
            default:              blend_factor = '0;
        endcase
    endfunction

endpackage

### design/rbfu_lane.sv
// One color channel of the blend unit: factor selection, registered products,
// then sum, rounding division by 255 and clamp. Depends on rbfu_pkg.
module rbfu_lane (
    input  logic                     aclk,
    input  logic                     en,
    input  rbfu_pkg::blend_cfg_t     cfg,
    input  logic                     is_alpha,
    input  logic [7:0]               s_ch,
    input  logic [7:0]               d_ch,
    input  logic [7:0]               s_a,
    input  logic [7:0]               d_a,
    output logic [7:0]               result
);
    import rbfu_pkg::*;

    logic [CHAN_W-1:0]     fs;
    logic [CHAN_W-1:0]     fd;
    logic [2*CHAN_W-1:0]   prod_s_reg;
    logic [2*CHAN_W-1:0]   prod_d_reg;
    logic [2*CHAN_W+1:0]   rounded;
    logic [2*CHAN_W:0]     approx;

    assign fs = blend_factor(cfg.src_sel, s_ch, d_ch, s_a, d_a, is_alpha);
    assign fd = blend_factor(cfg.dst_sel, s_ch, d_ch, s_a, d_a, is_alpha);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_s_reg <= s_ch * fs;
            prod_d_reg <= d_ch * fd;
        end
    end

    // Division by 255 is exact below 65535 with the add-and-shift form; anything
    // at or above 255 * 256 saturates.
    assign rounded = 18'(prod_s_reg) + 18'(prod_d_reg) + 18'd127;
    assign approx  = 17'(rounded[15:0]) + 17'd1 + 17'(rounded[15:8]);

    always_comb begin
        if (rounded >= 18'd65280) begin
            result = UNORM_ONE;
        end else begin
            result = approx[15:8];
        end
    end

endmodule

### design/rgba8_blend_factor_unit_core.sv
// Top level of the RGBA8 blend unit: four channel lanes, pipeline control,
// factor registers and output register. Depends on rbfu_pkg, rbfu_lane, assert_macros.svh.
//
// Usage: each beat on the s_ channel carries one source and one destination
// pixel; each beat on the m_ channel carries the blended pixel. Every channel is
// computed as src * Fs + dst * Fd, rounded back to unorm8 and clamped to 255.
// The factors Fs and Fd come from two registers written through the cfg_ port
// (index 0 source factor, index 1 destination factor, low 4 bits used, codes
// 11 to 15 give a zero factor). Write them only while no pixel is in flight.
// The accepting edge loads the product stage; the output register takes the beat
// when free, and the result shows on m_tvalid. Throughput: one pixel per cycle while
// m_tready is high, set by the four lanes each holding two 8x8 multipliers in parallel.
// When the receiver stalls, the output register holds its beat and the product
// stage still fills, so two beats are held before s_tready drops.
// Reset (aresetn low, synchronous) empties the pipeline and sets the source
// factor to one and the destination factor to zero.
`include "assert_macros.svh"

module rgba8_blend_factor_unit_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
    input  logic [63:0]                          s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0]                          m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [rbfu_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [rbfu_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import rbfu_pkg::*;

    blend_cfg_t             cfg_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   en1;
    logic                   en2;
    logic [31:0]            data_reg;
    logic [31:0]            data_next;
    logic [CHAN_W-1:0]      s_a;
    logic [CHAN_W-1:0]      d_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_sel <= FACTOR_ONE;
            cfg_reg.dst_sel <= FACTOR_ZERO;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SRC_FACTOR: cfg_reg.src_sel <= factor_sel_t'(cfg_wdata);
                REG_DST_FACTOR: cfg_reg.dst_sel <= factor_sel_t'(cfg_wdata);
                default: ;
            endcase
        end
    end

    assign en2      = !v2_reg || m_tready;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    assign s_a = s_tdata[31:24];
    assign d_a = s_tdata[63:56];

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        rbfu_lane u_lane (
            .aclk     (aclk),
            .en       (en1),
            .cfg      (cfg_reg),
            .is_alpha (i == NUM_LANES - 1),
            .s_ch     (s_tdata[i*CHAN_W +: CHAN_W]),
            .d_ch     (s_tdata[(NUM_LANES+i)*CHAN_W +: CHAN_W]),
            .s_a      (s_a),
            .d_a      (d_a),
            .result   (data_next[i*CHAN_W +: CHAN_W])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_tvalid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = v2_reg;
    assign m_tdata  = data_reg;

    `RBFU_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_tvalid && s_tready, v1_reg,
        "accepted beat did not enter the product stage")
    `RBFU_ASSERT_NEXT(a_stage_moves, aclk, aresetn, v1_reg && en2, m_tvalid,
        "product stage beat was lost before the output register")
    `RBFU_ASSERT(a_stall_full, aclk, aresetn, !s_tready |-> (v1_reg && m_tvalid && !m_tready),
        "input stalled while the pipeline had room")

endmodule
